>>> rtl/core/window_median_filter_unit_macros.svh
// ---------------------------------------------------------------------------
// Window median filter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef WINDOW_MEDIAN_FILTER_UNIT_MACROS_SVH
`define WINDOW_MEDIAN_FILTER_UNIT_MACROS_SVH

// Same-cycle implication.
`define WMF_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window median filter check failed");

// Next-cycle implication.
`define WMF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("window median filter check failed");

`endif

>>> rtl/core/wmf_pkg.sv
// ---------------------------------------------------------------------------
// Window median filter package
// Sizes, payload types and register codes shared by the filter modules.
// ---------------------------------------------------------------------------
package wmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_WINDOW = 7;
    localparam int LINES      = MAX_WINDOW - 1;
    localparam int WIN_N      = MAX_WINDOW * MAX_WINDOW;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int RANK_W     = $clog2(WIN_N + 1);

    localparam int PIX_W  = 8;
    localparam int COL_W  = 10;
    localparam int ROW_W  = 12;
    localparam int IW_W   = 11;
    localparam int WIN_W  = 3;
    localparam int CFG_W  = 12;
    localparam int IDX_W  = 3;
    localparam int MAX_HEIGHT = 4095;

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_WIN_HEIGHT   = 3'd2,
        REG_WIN_WIDTH    = 3'd3,
        REG_ANCHOR_ROW   = 3'd4,
        REG_ANCHOR_COL   = 3'd5
    } wmf_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } wmf_in_t;

    typedef struct packed {
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic [PIX_W-1:0] median;
        logic             frame_last;
    } wmf_out_t;

    // Per-item control carried down the pipeline.
    typedef struct packed {
        logic             emit;
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic             frame_last;
    } wmf_meta_t;

    // Which window elements take part and which sorted rank is wanted.
    typedef struct packed {
        logic [WIN_N-1:0]  mask;
        logic [RANK_W-1:0] half;
    } wmf_sel_t;

    typedef logic [MAX_WINDOW-1:0][PIX_W-1:0] wmf_col_t;
    typedef logic [LINES-1:0][PIX_W-1:0]      wmf_line_t;
    typedef logic [WIN_N-1:0][PIX_W-1:0]      wmf_win_t;

endpackage

>>> rtl/core/wmf_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ---------------------------------------------------------------------------
module wmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/wmf_win_cell.sv
// ---------------------------------------------------------------------------
// Window column cell
// Holds one window column and loads col_in, its neighbor's column or the new column, on each shift.
// ---------------------------------------------------------------------------
module wmf_win_cell (
    input  logic              clk,
    input  logic              shift,
    input  wmf_pkg::wmf_col_t col_in,
    output wmf_pkg::wmf_col_t col_out
);
    import wmf_pkg::*;

    wmf_col_t col_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

>>> rtl/core/wmf_median.sv
// ---------------------------------------------------------------------------
// Window median selector
// Three stages: pairwise compare matrix, rank count, rank match and select.
// ---------------------------------------------------------------------------
module wmf_median (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wmf_pkg::wmf_win_t  win,
    input  wmf_pkg::wmf_sel_t  sel,
    input  wmf_pkg::wmf_meta_t meta,
    output logic               out_valid,
    input  logic               out_ready,
    output wmf_pkg::wmf_out_t  out_data
);
    import wmf_pkg::*;

    logic en3, en4, en5;
    logic v3_reg, v3_next, v4_reg, v4_next, v5_reg, v5_next;

    logic [WIN_N-1:0][WIN_N-1:0] lt_comb;
    logic [WIN_N-1:0][WIN_N-1:0] lt3_reg;
    wmf_win_t                    vals3_reg, vals4_reg;
    wmf_sel_t                    sel3_reg, sel4_reg;
    wmf_meta_t                   meta3_reg, meta4_reg;

    logic [WIN_N-1:0][RANK_W-1:0] rank_comb;
    logic [WIN_N-1:0][RANK_W-1:0] rank4_reg;
    logic [PIX_W-1:0]             med_comb;
    wmf_out_t                     out_reg;

    assign en5 = !v5_reg || out_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign in_ready = en3;

    // Element j counts below element i when it is smaller, or equal and
    // earlier, so ranks among the taking-part elements are all distinct.
    always_comb
    begin
        for (int i = 0; i < WIN_N; i++)
        begin
            for (int j = 0; j < WIN_N; j++)
            begin
                lt_comb[i][j] = sel.mask[j] &&
                    ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i)));
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < WIN_N; i++)
        begin
            rank_comb[i] = RANK_W'($countones(lt3_reg[i]));
        end
    end

    always_comb
    begin
        med_comb = '0;
        for (int i = 0; i < WIN_N; i++)
        begin
            if (sel4_reg.mask[i] && (rank4_reg[i] == sel4_reg.half))
            begin
                med_comb = med_comb | vals4_reg[i];
            end
        end
    end

    always_comb
    begin
        v3_next = v3_reg;
        v4_next = v4_reg;
        v5_next = v5_reg;
        if (en3)
        begin
            v3_next = in_valid;
        end
        if (en4)
        begin
            v4_next = v3_reg;
        end
        if (en5)
        begin
            v5_next = v4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            lt3_reg   <= lt_comb;
            vals3_reg <= win;
            sel3_reg  <= sel;
            meta3_reg <= meta;
        end
        if (en4)
        begin
            rank4_reg <= rank_comb;
            vals4_reg <= vals3_reg;
            sel4_reg  <= sel3_reg;
            meta4_reg <= meta3_reg;
        end
        if (en5)
        begin
            out_reg.out_col    <= meta4_reg.out_col;
            out_reg.out_row    <= meta4_reg.out_row;
            out_reg.median     <= med_comb;
            out_reg.frame_last <= meta4_reg.frame_last;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = out_reg;

endmodule

>>> rtl/core/window_median_filter_unit.sv
// ---------------------------------------------------------------------------
// Window median filter unit
// Streaming 2-D median filter over raster-order 8-bit gray pixels.
// ---------------------------------------------------------------------------
// Pixels enter on the in channel (valid/ready), one item per clock while
// in_ready is high; frame_start marks the first pixel of an image. When
// a pixel closes a window that lies fully inside the image, one item
// leaves on the out channel with the anchor coordinates and the window
// median; border positions produce nothing. After its pixel is accepted,
// a result passes through the line RAM read at acceptance, then window
// column shift, compare matrix, rank count, and rank select into the
// output register. Throughput is one pixel per cycle while the output does
// not stall, set by the single line RAM read and write-back per pixel and
// the seven window column cells shifting once per pixel.
// The configuration port is a plain write port (cfg_we, cfg_index, cfg_data);
// the user must write it only while the block is idle; the block does not enforce it.
// Reset clears the pixel position and loads the default registers; the line
// and window stores are not cleared and need no clearing pass. When the
// receiver stalls, every pipeline stage holds and empty stages still fill,
// so in_ready drops only once all stages are occupied.
// ---------------------------------------------------------------------------
`include "window_median_filter_unit_macros.svh"

module window_median_filter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  wmf_pkg::wmf_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output wmf_pkg::wmf_out_t             out_data,
    input  logic                          cfg_we,
    input  logic [wmf_pkg::IDX_W-1:0]     cfg_index,
    input  logic [wmf_pkg::CFG_W-1:0]     cfg_data
);
    import wmf_pkg::*;

    // Configuration registers.
    logic [IW_W-1:0]  image_width_reg;
    logic [ROW_W-1:0] image_height_reg;
    logic [WIN_W-1:0] win_height_reg, win_width_reg, anchor_row_reg, anchor_col_reg;

    logic [IW_W-1:0]  w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [WIN_W-1:0] wh_eff, ww_eff, ay_eff, ax_eff;

    // Pixel position.
    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [COL_W-1:0] c_cur;
    logic [ROW_W:0]   r_tmp;
    logic [ROW_W-1:0] r_cur;
    logic [IW_W-1:0]  c_inc;
    logic [ROW_W:0]   r_inc;
    wmf_meta_t        meta_in;

    // Pipeline control.
    logic accept, en1, en2, med_ready;
    logic s1_v_reg, s1_v_next, s2_v_reg, s2_v_next;

    logic [COL_W-1:0] s1_col_reg;
    logic [PIX_W-1:0] s1_px_reg;
    wmf_meta_t        s1_meta_reg, s2_meta_reg;
    logic             s1_byp_reg;
    wmf_line_t        s1_byp_data_reg;

    wmf_line_t ram_q, line_rd, line_wd;
    wmf_col_t  new_col;
    wmf_col_t  cols [MAX_WINDOW];
    wmf_win_t  win;
    wmf_sel_t  sel;
    logic [2*WIN_W-1:0] win_n;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IW_W'(640);
            image_height_reg <= ROW_W'(480);
            win_height_reg   <= WIN_W'(3);
            win_width_reg    <= WIN_W'(3);
            anchor_row_reg   <= WIN_W'(1);
            anchor_col_reg   <= WIN_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IW_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[ROW_W-1:0];
                REG_WIN_HEIGHT:   win_height_reg   <= cfg_data[WIN_W-1:0];
                REG_WIN_WIDTH:    win_width_reg    <= cfg_data[WIN_W-1:0];
                REG_ANCHOR_ROW:   anchor_row_reg   <= cfg_data[WIN_W-1:0];
                REG_ANCHOR_COL:   anchor_col_reg   <= cfg_data[WIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Out-of-range settings are clamped into the usable range.
    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = IW_W'(1);
        else if (image_width_reg > IW_W'(MAX_WIDTH))
            w_eff = IW_W'(MAX_WIDTH);
        else
            w_eff = image_width_reg;

        h_eff = (image_height_reg == '0) ? ROW_W'(1) : image_height_reg;

        if (win_height_reg == '0)
            wh_eff = WIN_W'(1);
        else if (win_height_reg > WIN_W'(MAX_WINDOW))
            wh_eff = WIN_W'(MAX_WINDOW);
        else
            wh_eff = win_height_reg;

        if (win_width_reg == '0)
            ww_eff = WIN_W'(1);
        else if (win_width_reg > WIN_W'(MAX_WINDOW))
            ww_eff = WIN_W'(MAX_WINDOW);
        else
            ww_eff = win_width_reg;

        ay_eff = (anchor_row_reg < wh_eff) ? anchor_row_reg : wh_eff - WIN_W'(1);
        ax_eff = (anchor_col_reg < ww_eff) ? anchor_col_reg : ww_eff - WIN_W'(1);
    end

    // ---------------- position and result tags ----------------
    always_comb
    begin
        if (in_data.frame_start)
        begin
            c_cur = '0;
            r_tmp = '0;
        end
        else if ({1'b0, col_count_reg} >= w_eff)
        begin
            c_cur = '0;
            r_tmp = {1'b0, row_count_reg} + (ROW_W+1)'(1);
        end
        else
        begin
            c_cur = col_count_reg;
            r_tmp = {1'b0, row_count_reg};
        end
        r_cur = (r_tmp >= {1'b0, h_eff}) ? '0 : r_tmp[ROW_W-1:0];

        meta_in.emit = (r_cur >= ROW_W'(wh_eff - WIN_W'(1))) &&
                       (c_cur >= COL_W'(ww_eff - WIN_W'(1)));
        meta_in.out_col = c_cur + COL_W'(ax_eff) - COL_W'(ww_eff - WIN_W'(1));
        meta_in.out_row = r_cur + ROW_W'(ay_eff) - ROW_W'(wh_eff - WIN_W'(1));
        meta_in.frame_last = (r_cur == h_eff - ROW_W'(1)) &&
                             ({1'b0, c_cur} == w_eff - IW_W'(1));

        c_inc = {1'b0, c_cur} + IW_W'(1);
        r_inc = {1'b0, r_cur} + (ROW_W+1)'(1);
        if (c_inc >= w_eff)
        begin
            col_count_next = '0;
            row_count_next = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[ROW_W-1:0];
        end
        else
        begin
            col_count_next = c_inc[COL_W-1:0];
            row_count_next = r_cur;
        end
    end

    // ---------------- pipeline handshake ----------------
    // Items that close no in-image window leave after the window shift.
    assign en2    = !s2_v_reg || !s2_meta_reg.emit || med_ready;
    assign en1    = !s1_v_reg || en2;
    assign in_ready = en1;
    assign accept = in_valid && en1;

    always_comb
    begin
        s1_v_next = s1_v_reg;
        s2_v_next = s2_v_reg;
        if (en1)
        begin
            s1_v_next = in_valid;
        end
        if (en2)
        begin
            s2_v_next = s1_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
            if (accept)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg  <= c_cur;
            s1_px_reg   <= in_data.pixel;
            s1_meta_reg <= meta_in;
            // The write-back of the item ahead lands in the same cycle as
            // this read, so a read of that column takes the written word.
            s1_byp_reg      <= s1_v_reg && (s1_col_reg == c_cur);
            s1_byp_data_reg <= line_wd;
        end
        if (en2 && s1_v_reg)
        begin
            s2_meta_reg <= s1_meta_reg;
        end
    end

    // ---------------- line store ----------------
    // Each column word holds the previous rows oldest first; it is rewritten
    // shifted by one row with the new pixel on top while the item sits in
    // the first stage.
    assign line_rd = s1_byp_reg ? s1_byp_data_reg : ram_q;

    always_comb
    begin
        for (int k = 0; k < LINES - 1; k++)
        begin
            line_wd[k] = line_rd[k+1];
        end
        line_wd[LINES-1] = s1_px_reg;
        for (int k = 0; k < LINES; k++)
        begin
            new_col[k] = line_rd[k];
        end
        new_col[MAX_WINDOW-1] = s1_px_reg;
    end

    wmf_ram #(
        .WIDTH (LINES * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_v_reg),
        .waddr (s1_col_reg[ADDR_W-1:0]),
        .wdata (line_wd),
        .re    (accept),
        .raddr (c_cur[ADDR_W-1:0]),
        .rdata (ram_q)
    );

    // ---------------- window cells ----------------
    genvar gl;
    generate
        for (gl = 0; gl < MAX_WINDOW; gl++)
        begin : g_cell
            if (gl == MAX_WINDOW - 1)
            begin : g_last
                wmf_win_cell u_cell (
                    .clk     (clk),
                    .shift   (en2 && s1_v_reg),
                    .col_in  (new_col),
                    .col_out (cols[gl])
                );
            end
            else
            begin : g_mid
                wmf_win_cell u_cell (
                    .clk     (clk),
                    .shift   (en2 && s1_v_reg),
                    .col_in  (cols[gl+1]),
                    .col_out (cols[gl])
                );
            end
        end
    endgenerate

    // Window element index is row * MAX_WINDOW + column; the bottom-right
    // corner holds the newest pixel.
    assign win_n = wh_eff * ww_eff;

    always_comb
    begin
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            for (int l = 0; l < MAX_WINDOW; l++)
            begin
                win[k*MAX_WINDOW + l] = cols[l][k];
                sel.mask[k*MAX_WINDOW + l] = (k >= MAX_WINDOW - int'(wh_eff)) &&
                                             (l >= MAX_WINDOW - int'(ww_eff));
            end
        end
        sel.half = RANK_W'(win_n >> 1);
    end

    wmf_median u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_v_reg && s2_meta_reg.emit),
        .in_ready  (med_ready),
        .win       (win),
        .sel       (sel),
        .meta      (s2_meta_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // ---------------- assertions ----------------
    `WMF_ASSERT_NEXT(a_s1_hold, s1_v_reg && !en2, s1_v_reg && $stable(s1_col_reg))
    `WMF_ASSERT_NEXT(a_col_range, accept && !cfg_we, {1'b0, col_count_reg} < w_eff)
    `WMF_ASSERT_IMP(a_ready_chain, s1_v_reg && !s2_v_reg, in_ready)

endmodule
